// ===== rtl/tbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types, constants and helper functions of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package tbs_pkg;

	// Fixed-point format of the coordinates and the blend weights
	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = FRAC_BITS + 1;
	localparam logic [COORD_W-1:0] COORD_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [COORD_W-1:0] COORD_HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

	// Image sizes come from 9-bit registers; indices fit the same width
	localparam int SIZE_W = 9;
	localparam int POS_W  = COORD_W + SIZE_W + 1;

	// Shared multiplier: 24-bit value by 17-bit weight, 41-bit accumulator
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = COORD_W;
	localparam int ACC_W   = MUL_A_W + MUL_B_W;

	localparam int OUT_W   = 24;
	localparam logic [OUT_W-1:0] OUT_MAX = 24'(255) << FRAC_BITS;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_V       = 2'd2;

	// Request kinds carried on tuser
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// One operation of the shared multiply-accumulate unit
	typedef struct packed {
		logic               en;
		logic               accum;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mac_op_t;

	// Corner indices and weight along one axis
	typedef struct packed {
		logic [SIZE_W-1:0]    i0;
		logic [SIZE_W-1:0]    i1;
		logic [FRAC_BITS-1:0] frac;
	} corner_t;

	// Clamp a signed coordinate to the unit interval
	function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [17:0] c);
		logic [COORD_W-1:0] r;
		if (c[17]) begin
			r = '0;
		end else if (c[16:0] > COORD_ONE) begin
			r = COORD_ONE;
		end else begin
			r = c[16:0];
		end
		return r;
	endfunction

	// Split coord*size into clamped corner indices and the fraction weight.
	// The half-texel offset is folded in as +1/2 with the floor shifted by one.
	function automatic corner_t corner_split(input logic [POS_W-1:0] prod,
			input logic [SIZE_W-1:0] size);
		logic [POS_W-1:0]          pos;
		logic [POS_W-FRAC_BITS-1:0] whole;
		logic [POS_W-FRAC_BITS-1:0] fl;
		logic [SIZE_W-1:0]         last;
		corner_t                   r;
		pos   = prod + POS_W'(COORD_HALF);
		whole = pos[POS_W-1:FRAC_BITS];
		fl    = whole - 1'b1;
		last  = size - 1'b1;
		if (whole == '0) begin
			r.i0 = '0;
		end else if (fl > (POS_W-FRAC_BITS)'(last)) begin
			r.i0 = last;
		end else begin
			r.i0 = fl[SIZE_W-1:0];
		end
		r.i1   = (r.i0 == last) ? last : r.i0 + 1'b1;
		r.frac = pos[FRAC_BITS-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/texture_bilinear_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// texture_bilinear_sampler_unit
// Bilinear sampler of one byte channel over a loadable RGBA8 texel store.
// ----------------------------------------------------------------------------
// Requests enter on s_*; s_tuser selects the kind (0 writes a texel, 1 samples).
// A write request puts its texel into the store at the edge that accepts it,
// and s_tready stays high, so writes stream at one per cycle.
// A sample request clamps u and v and runs a 12-step sequence during which
// s_tready is held low. All multiplications (u*width, v*height, row*width and
// the six blend products) go through one shared multiply-accumulate unit, and
// the four texels come one per cycle from the single-port texture memory.
// Results leave through an output register on m_*; a new request is accepted
// while a finished result still waits there. If the receiver stalls, the next
// sample finishes its math and waits in its last step until the register frees.
// Configuration writes (cfg_we/cfg_index/cfg_data) land at the clock edge and
// must only happen while the block is idle. Reset sets width and height to
// 256 and flip_v to 1; the texture store is not cleared and needs no sweep,
// so reading a texel that was never written gives an undefined value.
// ----------------------------------------------------------------------------
module texture_bilinear_sampler_unit #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Config write port
	input  logic                             cfg_we,
	input  logic [tbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tbs_pkg::SIZE_W-1:0]       cfg_data,
	// Request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// tdata: texel_index[15:0], texel_rgba[47:16], u_coord[65:48],
	//        v_coord[83:66], channel[85:84], zero pad[87:86]
	input  logic [87:0]                      s_tdata,
	// tuser: opcode[0]
	input  logic                             s_tuser,
	// Result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// tdata: sample_value[23:0]
	output logic [tbs_pkg::OUT_W-1:0]        m_tdata
);
	import tbs_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_MUL_X  = 13'b0000000000010,
		S_MUL_Y  = 13'b0000000000100,
		S_CORN_Y = 13'b0000000001000,
		S_ROW0   = 13'b0000000010000,
		S_RD00   = 13'b0000000100000,
		S_RD10   = 13'b0000001000000,
		S_RD01   = 13'b0000010000000,
		S_RD11   = 13'b0000100000000,
		S_BLB    = 13'b0001000000000,
		S_BLY0   = 13'b0010000000000,
		S_BLY1   = 13'b0100000000000,
		S_DONE   = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic              flip_v_q;

	// Sample operands captured at accept
	logic [COORD_W-1:0] u_q;
	logic [COORD_W-1:0] v_q;
	logic [1:0]         ch_q;
	logic [SIZE_W-1:0]  w_q;
	logic [SIZE_W-1:0]  h_q;

	// Corner results and row bases
	logic [SIZE_W-1:0]    x0_q, x1_q, y0_q, y1_q;
	logic [FRAC_BITS-1:0] tx_q, ty_q;
	logic [AW-1:0]        base0_q, base1_q;
	logic [MUL_A_W-1:0]   a_q;

	// Output register
	logic             m_valid_q;
	logic [OUT_W-1:0] m_data_q;

	// Texture memory
	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;
	logic [AW-1:0] mem_addr;
	logic          mem_we;

	// Request fields
	logic [15:0]        in_index;
	logic [31:0]        in_rgba;
	logic signed [17:0] in_u;
	logic signed [17:0] in_v;
	logic [1:0]         in_ch;
	logic [31:0]        in_index32;
	logic               accept;

	logic [COORD_W-1:0] u_clamp, v_clamp;
	logic [SIZE_W-1:0]  w_eff, h_eff;
	corner_t            cx, cy;
	mac_op_t            mac_op;
	logic [ACC_W-1:0]   acc;
	logic [7:0]         texel_byte;
	logic [MUL_B_W-1:0] wx0, wx1, wy0, wy1;
	logic               done_fire;

	assign in_index   = s_tdata[15:0];
	assign in_rgba    = s_tdata[47:16];
	assign in_u       = s_tdata[65:48];
	assign in_v       = s_tdata[83:66];
	assign in_ch      = s_tdata[85:84];
	assign in_index32 = 32'(in_index);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Clamp coordinates, apply the v flip and clamp image sizes for a new sample
	always_comb begin
		u_clamp = clamp_coord(in_u);
		v_clamp = clamp_coord(in_v);
		if (flip_v_q) begin
			v_clamp = COORD_ONE - v_clamp;
		end
		if (width_q == '0) begin
			w_eff = SIZE_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = SIZE_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = SIZE_W'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = SIZE_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(256);
			height_q <= SIZE_W'(256);
			flip_v_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_FLIP_V:       flip_v_q <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// Corner split of the registered products
	assign cx = corner_split(acc[POS_W-1:0], w_q);
	assign cy = corner_split(acc[POS_W-1:0], h_q);

	assign texel_byte = rdata_q[{ch_q, 3'b000} +: 8];
	assign wx1 = MUL_B_W'(tx_q);
	assign wx0 = COORD_ONE - wx1;
	assign wy1 = MUL_B_W'(ty_q);
	assign wy0 = COORD_ONE - wy1;

	// Drive the shared multiplier from the sequencer step
	always_comb begin
		mac_op = '0;
		case (state_q)
			S_MUL_X: begin
				mac_op = '{en: 1'b1, accum: 1'b0, a: MUL_A_W'(u_q), b: MUL_B_W'(w_q)};
			end
			S_MUL_Y: begin
				mac_op = '{en: 1'b1, accum: 1'b0, a: MUL_A_W'(v_q), b: MUL_B_W'(h_q)};
			end
			S_ROW0: begin
				mac_op = '{en: 1'b1, accum: 1'b0, a: MUL_A_W'(y0_q), b: MUL_B_W'(w_q)};
			end
			S_RD00: begin
				mac_op = '{en: 1'b1, accum: 1'b0, a: MUL_A_W'(y1_q), b: MUL_B_W'(w_q)};
			end
			S_RD10: begin
				mac_op = '{en: 1'b1, accum: 1'b0, a: MUL_A_W'(texel_byte), b: wx0};
			end
			S_RD01: begin
				mac_op = '{en: 1'b1, accum: 1'b1, a: MUL_A_W'(texel_byte), b: wx1};
			end
			S_RD11: begin
				mac_op = '{en: 1'b1, accum: 1'b0, a: MUL_A_W'(texel_byte), b: wx0};
			end
			S_BLB: begin
				mac_op = '{en: 1'b1, accum: 1'b1, a: MUL_A_W'(texel_byte), b: wx1};
			end
			S_BLY0: begin
				mac_op = '{en: 1'b1, accum: 1'b0, a: a_q, b: wy0};
			end
			S_BLY1: begin
				mac_op = '{en: 1'b1, accum: 1'b1, a: a_q, b: wy1};
			end
			default: mac_op = '0;
		endcase
	end

	tbs_mac u_mac (
		.clk (clk),
		.op  (mac_op),
		.acc (acc)
	);

	// Memory address: write in idle, four corner reads during a sample
	always_comb begin
		mem_we   = 1'b0;
		mem_addr = in_index32[AW-1:0];
		case (state_q)
			S_IDLE: begin
				mem_we = accept && (s_tuser == OP_WRITE) && (in_index32 < 32'(DEPTH));
			end
			S_RD00:  mem_addr = acc[AW-1:0] + AW'(x0_q);
			S_RD10:  mem_addr = base0_q + AW'(x1_q);
			S_RD01:  mem_addr = base1_q + AW'(x0_q);
			S_RD11:  mem_addr = base1_q + AW'(x1_q);
			default: ;
		endcase
	end

	// Single-port texture store with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= in_rgba;
		end
		rdata_q <= mem[mem_addr];
	end

	assign done_fire = (state_q == S_DONE) && (!m_valid_q || m_tready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (accept && s_tuser == OP_SAMPLE) state_q <= S_MUL_X;
				S_MUL_X:  state_q <= S_MUL_Y;
				S_MUL_Y:  state_q <= S_CORN_Y;
				S_CORN_Y: state_q <= S_ROW0;
				S_ROW0:   state_q <= S_RD00;
				S_RD00:   state_q <= S_RD10;
				S_RD10:   state_q <= S_RD01;
				S_RD01:   state_q <= S_RD11;
				S_RD11:   state_q <= S_BLB;
				S_BLB:    state_q <= S_BLY0;
				S_BLY0:   state_q <= S_BLY1;
				S_BLY1:   state_q <= S_DONE;
				S_DONE:   if (done_fire) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers along the sequence
	always_ff @(posedge clk) begin
		if (accept && s_tuser == OP_SAMPLE) begin
			u_q  <= u_clamp;
			v_q  <= v_clamp;
			ch_q <= in_ch;
			w_q  <= w_eff;
			h_q  <= h_eff;
		end
		if (state_q == S_MUL_Y) begin
			x0_q <= cx.i0;
			x1_q <= cx.i1;
			tx_q <= cx.frac;
		end
		if (state_q == S_CORN_Y) begin
			y0_q <= cy.i0;
			y1_q <= cy.i1;
			ty_q <= cy.frac;
		end
		if (state_q == S_RD00) begin
			base0_q <= acc[AW-1:0];
		end
		if (state_q == S_RD10) begin
			base1_q <= acc[AW-1:0];
		end
		// Hold the top row blend, then swap in the bottom row blend
		if (state_q == S_RD11 || state_q == S_BLY0) begin
			a_q <= acc[MUL_A_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (done_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			m_data_q <= acc[FRAC_BITS +: OUT_W];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ===== rtl/tbs_mac.sv =====
// ----------------------------------------------------------------------------
// tbs_mac
// Shared multiply-accumulate unit: one product per cycle into a register.
// ----------------------------------------------------------------------------
module tbs_mac (
	input  logic                     clk,
	input  tbs_pkg::mac_op_t         op,
	output logic [tbs_pkg::ACC_W-1:0] acc
);
	import tbs_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] prod;

	assign prod = ACC_W'(op.a) * ACC_W'(op.b);

	// Load or accumulate the product, hold when idle
	always_ff @(posedge clk) begin
		if (op.en) begin
			acc_q <= (op.accum ? acc_q : '0) + prod;
		end
	end

	assign acc = acc_q;

endmodule

// ===== rtl/tbs_checker.sv =====
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks of the sampler's request and result streams.
// ----------------------------------------------------------------------------
module tbs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      s_tuser,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [tbs_pkg::OUT_W-1:0] m_tdata
);
	import tbs_pkg::*;

	// A sample request occupies the block on the next cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_SAMPLE |=> !s_tready)
		else $error("ready high right after a sample request");

	// A texel write never stalls the request stream
	a_write_stream: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_WRITE |=> s_tready)
		else $error("ready dropped after a texel write");

	// A stalled result holds its value
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// A blend of bytes never exceeds full scale
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= OUT_MAX)
		else $error("result above full scale");

endmodule

bind texture_bilinear_sampler_unit tbs_checker u_tbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/sv/sampler_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampler_scoreboard_pkg
// Texel mirror, register copy and expected-value queue for the sampler bench.
// ----------------------------------------------------------------------------
// Every accepted request is noted here: texel writes update the mirror and
// samples push the blended value the block must return. Results are checked
// in order against the oldest expected value.
// ----------------------------------------------------------------------------
package sampler_scoreboard_pkg;

	import tbs_pkg::*;

	localparam int UNIT         = 1 << FRAC_BITS;
	localparam int HALF_UNIT    = UNIT / 2;
	localparam int IMG_MAX_W    = 256;
	localparam int IMG_MAX_H    = 256;
	localparam int REPORT_LIMIT = 10;

	// Corner indices and weight along one axis
	typedef struct packed {
		int i0;
		int i1;
		int frac;
	} axis_t;

	class sampler_scoreboard;
		logic [31:0]      texel_mirror[int];
		logic [SIZE_W-1:0] width_reg  = 9'd256;
		logic [SIZE_W-1:0] height_reg = 9'd256;
		logic             flip_reg   = 1'b1;
		logic [OUT_W-1:0] expected_values[$];
		int               failures        = 0;
		int               results_checked = 0;
		int               writes_seen     = 0;
		int               samples_seen    = 0;

		// Zero reads as one, anything above the store side saturates
		function int fit_size(logic [SIZE_W-1:0] s, int limit);
			if (s == 0) begin
				return 1;
			end
			if (int'(s) > limit) begin
				return limit;
			end
			return int'(s);
		endfunction

		function int image_w();
			return fit_size(width_reg, IMG_MAX_W);
		endfunction

		function int image_h();
			return fit_size(height_reg, IMG_MAX_H);
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] index, logic [SIZE_W-1:0] data);
			case (index)
				REG_IMAGE_WIDTH: begin
					width_reg = data;
				end
				REG_IMAGE_HEIGHT: begin
					height_reg = data;
				end
				REG_FLIP_V: begin
					flip_reg = data[0];
				end
				default: begin
				end
			endcase
		endfunction

		function int unit_clamp(logic signed [17:0] c);
			if (c < 0) begin
				return 0;
			end
			if (c > UNIT) begin
				return UNIT;
			end
			return int'(c);
		endfunction

		// Position c*size - 1/2 is kept shifted up by one texel so it never goes negative
		function axis_t split_axis(int c, int size);
			longint pos;
			longint fl;
			axis_t  r;
			pos = longint'(c) * size + HALF_UNIT;
			fl  = (pos >>> FRAC_BITS) - 1;
			if (fl > size - 1) begin
				fl = size - 1;
			end
			if (fl < 0) begin
				fl = 0;
			end
			r.i0   = int'(fl);
			r.i1   = (fl + 1 > size - 1) ? size - 1 : int'(fl) + 1;
			r.frac = int'(pos & (UNIT - 1));
			return r;
		endfunction

		function void locate(logic [17:0] u, logic [17:0] v, output axis_t ax, output axis_t ay);
			int uc;
			int vc;
			uc = unit_clamp(u);
			vc = unit_clamp(v);
			if (flip_reg) begin
				vc = UNIT - vc;
			end
			ax = split_axis(uc, image_w());
			ay = split_axis(vc, image_h());
		endfunction

		function int texel_addr(int x, int y);
			return y * image_w() + x;
		endfunction

		function bit holds_texel(int addr);
			return texel_mirror.exists(addr);
		endfunction

		// Store addresses of the four texels a sample reads
		function logic [3:0][15:0] footprint(logic [17:0] u, logic [17:0] v);
			axis_t ax;
			axis_t ay;
			logic [3:0][15:0] spots;
			locate(u, v, ax, ay);
			spots[0] = 16'(texel_addr(ax.i0, ay.i0));
			spots[1] = 16'(texel_addr(ax.i1, ay.i0));
			spots[2] = 16'(texel_addr(ax.i0, ay.i1));
			spots[3] = 16'(texel_addr(ax.i1, ay.i1));
			return spots;
		endfunction

		function longint texel_byte(int x, int y, logic [1:0] ch);
			logic [31:0] t;
			t = texel_mirror[texel_addr(x, y)];
			return longint'(t[8*ch +: 8]);
		endfunction

		// Blend along x on both rows, then along y; keep 16 fraction bits
		function logic [OUT_W-1:0] bilinear_value(logic [17:0] u, logic [17:0] v, logic [1:0] ch);
			axis_t  ax;
			axis_t  ay;
			longint top;
			longint bottom;
			longint blend;
			locate(u, v, ax, ay);
			top    = texel_byte(ax.i0, ay.i0, ch) * (UNIT - ax.frac)
				+ texel_byte(ax.i1, ay.i0, ch) * ax.frac;
			bottom = texel_byte(ax.i0, ay.i1, ch) * (UNIT - ax.frac)
				+ texel_byte(ax.i1, ay.i1, ch) * ax.frac;
			blend  = top * (UNIT - ay.frac) + bottom * ay.frac;
			return blend[FRAC_BITS +: OUT_W];
		endfunction

		function void note_request(logic op, logic [15:0] index, logic [31:0] rgba,
				logic [17:0] u, logic [17:0] v, logic [1:0] ch);
			if (op == OP_WRITE) begin
				texel_mirror[int'(index)] = rgba;
				writes_seen++;
			end else begin
				expected_values.push_back(bilinear_value(u, v, ch));
				samples_seen++;
			end
		endfunction

		function void check_result(logic [OUT_W-1:0] actual);
			logic [OUT_W-1:0] want;
			if (expected_values.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("Result %h arrived with no sample outstanding", actual);
				end
				return;
			end
			want = expected_values.pop_front();
			results_checked++;
			if (actual !== want) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("Sample value mismatch on result %0d: expected %h, got %h",
						results_checked, want, actual);
				end
			end
		endfunction

		function int pending();
			return expected_values.size();
		endfunction
	endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the bilinear texture sampler.
// ----------------------------------------------------------------------------
// Loads texels and samples them under a series of image sizes and v-flip
// settings, including zero and oversized sizes. Every texel a sample reads is
// written first. The sender runs in random bursts and the receiver stalls on
// its own pattern; each sample value is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb;

	import tbs_pkg::*;
	import sampler_scoreboard_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 24;

	// Register index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0]    cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	// tdata: texel_index[15:0], texel_rgba[47:16], u_coord[65:48],
	//        v_coord[83:66], channel[85:84], zero pad[87:86]
	logic [87:0]          s_tdata   = '0;
	// tuser: opcode[0]
	logic                 s_tuser   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	// tdata: sample_value[23:0]
	logic [OUT_W-1:0]     m_tdata;

	sampler_scoreboard sb;
	int cycle_count   = 0;
	int ready_left    = 0;
	int burst_left    = 0;
	int settings_used = 1;

	texture_bilinear_sampler_unit #(
		.MAX_WIDTH (IMG_MAX_W),
		.MAX_HEIGHT(IMG_MAX_H)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d samples outstanding",
				cycle_count, sb.pending());
			$display("Verification failed");
			$finish;
		end
	end

	// Check accepted results, then pick the next receiver stall
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			sb.check_result(m_tdata);
		end
		if (ready_left > 0) begin
			ready_left--;
		end else if ($urandom_range(0, 3) == 0) begin
			m_tready   <= 1'b0;
			ready_left = $urandom_range(1, 20);
		end else begin
			m_tready   <= 1'b1;
			ready_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
		end
	end

	// Send one request; hold it until accepted, gap between bursts
	task automatic push_request(input logic op, input logic [15:0] index,
			input logic [31:0] rgba, input logic [17:0] u, input logic [17:0] v,
			input logic [1:0] ch);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 16);
		end
		burst_left--;
		s_tuser  <= op;
		s_tdata  <= {2'b00, ch, v, u, rgba, index};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (s_tready !== 1'b1) begin
			@(posedge clk);
		end
		sb.note_request(op, index, rgba, u, v, ch);
	endtask

	// Texel write with random content in the unused fields
	task automatic write_texel(input logic [15:0] index, input logic [31:0] rgba);
		push_request(OP_WRITE, index, rgba, 18'($urandom), 18'($urandom), 2'($urandom));
	endtask

	// Load any texel the sample will read that was never written, then sample
	task automatic sample_texture(input logic [17:0] u, input logic [17:0] v,
			input logic [1:0] ch);
		logic [3:0][15:0] spots;
		spots = sb.footprint(u, v);
		for (int k = 0; k < 4; k++) begin
			if (!sb.holds_texel(int'(spots[k]))) begin
				write_texel(spots[k], $urandom);
			end
		end
		push_request(OP_SAMPLE, 16'($urandom), $urandom, u, v, ch);
	endtask

	// Drop valid and wait until every expected sample has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [SIZE_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.set_register(index, data);
	endtask

	task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
			input logic [SIZE_W-1:0] flip);
		drain_results();
		write_register(REG_IMAGE_WIDTH, w);
		write_register(REG_IMAGE_HEIGHT, h);
		write_register(REG_FLIP_V, flip);
		settings_used++;
	endtask

	// Mostly in-range coordinates, some on edges and texel centers, some anywhere
	function automatic logic [17:0] pick_coord(input int size);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			return 18'($urandom_range(0, UNIT));
		end else if (sel < 72) begin
			return 18'(((2 * $urandom_range(0, size - 1) + 1) * UNIT) / (2 * size));
		end else if (sel < 86) begin
			case ($urandom_range(0, 4))
				0: return 18'(0);
				1: return 18'(UNIT);
				2: return 18'(1);
				3: return 18'(UNIT - 1);
				default: return 18'(HALF_UNIT);
			endcase
		end
		return 18'($urandom);
	endfunction

	// Send about count requests, counting the texel loads a sample needs
	task automatic random_items(input int count);
		int pick;
		int w;
		int h;
		int start;
		start = sb.writes_seen + sb.samples_seen;
		while (sb.writes_seen + sb.samples_seen - start < count) begin
			w    = sb.image_w();
			h    = sb.image_h();
			pick = $urandom_range(0, 99);
			if (pick < 28) begin
				write_texel(16'($urandom_range(0, w * h - 1)), $urandom);
			end else if (pick < 36) begin
				write_texel(16'($urandom), $urandom);
			end else begin
				sample_texture(pick_coord(w), pick_coord(h), 2'($urandom));
			end
		end
	endtask

	// Field extremes, both edges, center, every channel
	task automatic directed_checks();
		push_request(OP_WRITE, 16'h0000, 32'h0000_0000, 18'h20000, 18'h1FFFF, 2'd3);
		push_request(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 18'h1FFFF, 18'h20000, 2'd0);
		sample_texture(18'h20000, 18'h1FFFF, 2'd0);
		sample_texture(18'(UNIT), 18'h00000, 2'd1);
		sample_texture(18'(HALF_UNIT), 18'(HALF_UNIT), 2'd2);
		sample_texture(18'h00001, 18'(UNIT - 1), 2'd3);
		sample_texture(18'h1FFFF, 18'h20000, 2'd3);
		sample_texture(18'(21 * 128), 18'(UNIT), 2'd0);
		sample_texture(18'h00000, 18'h00000, 2'd2);
	endtask

	initial begin
		sb = new;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Reset settings: 256 x 256, v flipped
		directed_checks();
		random_items(60);

		configure(9'd1, 9'd1, 9'd0);
		random_items(40);
		configure(9'd0, 9'd0, 9'd1);
		random_items(30);
		configure(9'd2, 9'd3, 9'd1);
		random_items(70);
		configure(9'd511, 9'd257, 9'h1FE);
		random_items(50);
		configure(9'd257, 9'd1, 9'd0);
		random_items(40);
		configure(9'd1, 9'd256, 9'd1);
		random_items(40);
		repeat (3) begin
			configure(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)), 9'($urandom));
			random_items(60);
		end

		// Unknown register index must leave the settings alone
		configure(9'd256, 9'd256, 9'h001);
		write_register(REG_UNKNOWN, 9'($urandom));
		random_items(40);

		drain_results();
		$display("Covered %0d texel writes and %0d samples over %0d image settings.",
			sb.writes_seen, sb.samples_seen, settings_used);
		$display("Checked %0d sample values, %0d failures.", sb.results_checked, sb.failures);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
